@@ src/kndxt_pkg.sv @@
// Package for the keyed nested djb2-xor tag block.
// Holds constants, state and register codes, command/status structs and the hash step.
// No dependencies.
package kndxt_pkg;

  localparam int PAD_BLOCK_BYTES_DEF  = 64;
  localparam int KEY_LENGTH_BYTES_DEF = 32;
  localparam int KEY_WORDS            = 4;
  localparam int KEY_WORD_W           = 64;
  localparam int KEY_BYTES_MAX        = 32;
  localparam int CFG_INDEX_W          = 2;
  localparam int HASH_W               = 32;
  localparam int BYTE_W               = 8;
  localparam int HASH_SHIFT           = 5;

  localparam logic [BYTE_W-1:0] INNER_PAD = 8'h36;
  localparam logic [BYTE_W-1:0] OUTER_PAD = 8'h5C;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_IN,
    ST_MSG,
    ST_PAD_OUT,
    ST_TAIL
  } state_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_0_7,
    REG_KEY_8_15,
    REG_KEY_16_23,
    REG_KEY_24_31
  } reg_index_t;

  typedef struct packed {
    logic load;
    logic pad_in_step;
    logic msg_step;
    logic pad_out_step;
    logic tail_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic pad_last;
    logic tail_last;
    logic last;
  } dp_status_t;

  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] m;
    m = (h << HASH_SHIFT) + h;
    return m ^ {{(HASH_W-BYTE_W){1'b0}}, b};
  endfunction

endpackage

@@ src/kndxt_ctrl.sv @@
// Controller for the keyed nested djb2-xor tag block.
// Sequences pad passes, message folds and the outer tail; owns the handshakes.
// Depends on kndxt_pkg.
module kndxt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kndxt_pkg::dp_cmd_t    cmd,
  input  kndxt_pkg::dp_status_t status
);
  import kndxt_pkg::*;

  state_t state, state_next;
  logic   in_message, in_message_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_message <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      in_message <= in_message_next;
      out_valid  <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_message_next = in_message;
    out_valid_next  = out_valid && !out_ready;
    cmd             = '0;
    in_ready        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load        = 1'b1;
          in_message_next = 1'b1;
          state_next      = in_message ? ST_MSG : ST_PAD_IN;
        end
      end
      ST_PAD_IN: begin
        cmd.pad_in_step = 1'b1;
        if (status.pad_last) state_next = ST_MSG;
      end
      ST_MSG: begin
        cmd.msg_step = 1'b1;
        state_next   = status.last ? ST_PAD_OUT : ST_IDLE;
      end
      ST_PAD_OUT: begin
        cmd.pad_out_step = 1'b1;
        if (status.pad_last) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        if (!status.tail_last) begin
          cmd.tail_step = 1'b1;
        end else if (!out_valid || out_ready) begin
          // hold the final step until the output register is free
          cmd.tail_step   = 1'b1;
          cmd.finish      = 1'b1;
          out_valid_next  = 1'b1;
          in_message_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ src/kndxt_dp.sv @@
// Datapath for the keyed nested djb2-xor tag block.
// Key registers, inner and outer hash registers, pad counter and output register.
// Depends on kndxt_pkg.
module kndxt_dp #(
  parameter int PAD_BLOCK_BYTES  = kndxt_pkg::PAD_BLOCK_BYTES_DEF,
  parameter int KEY_LENGTH_BYTES = kndxt_pkg::KEY_LENGTH_BYTES_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [kndxt_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [kndxt_pkg::KEY_WORD_W-1:0]           cfg_data,
  input  logic [kndxt_pkg::BYTE_W-1:0]               msg_byte,
  input  logic                                       byte_present,
  input  logic                                       end_of_message,
  input  logic [kndxt_pkg::HASH_W-1:0]               expected_tag,
  input  kndxt_pkg::dp_cmd_t                         cmd,
  output kndxt_pkg::dp_status_t                      status,
  output logic [kndxt_pkg::HASH_W-1:0]               tag,
  output logic                                       tag_matches
);
  import kndxt_pkg::*;

  localparam int CW = $clog2(PAD_BLOCK_BYTES);
  localparam int KIW = $clog2(KEY_BYTES_MAX);

  logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key;
  logic [KEY_BYTES_MAX-1:0][BYTE_W-1:0] key_b;
  logic [HASH_W-1:0]                    hash;
  logic [HASH_W/BYTE_W-1:0][BYTE_W-1:0] hash_b;
  logic [HASH_W-1:0]                    ohash;
  logic [HASH_W-1:0]                    tail_res;
  logic [CW-1:0]                        cnt;
  logic [BYTE_W-1:0]                    byte_r;
  logic                                 present_r;
  logic                                 last_r;
  logic [HASH_W-1:0]                    expected_r;
  logic                                 in_key;
  logic [BYTE_W-1:0]                    key_sel;
  logic [BYTE_W-1:0]                    pad_byte;

  assign key_b    = key;
  assign hash_b   = hash;
  assign in_key   = {1'b0, cnt} < (CW+1)'(KEY_LENGTH_BYTES);
  assign key_sel  = in_key ? key_b[cnt[KIW-1:0]] : '0;
  assign pad_byte = key_sel ^ (cmd.pad_in_step ? INNER_PAD : OUTER_PAD);
  assign tail_res = hash_step(ohash, hash_b[cnt[1:0]]);

  assign status.pad_last  = cnt == CW'(PAD_BLOCK_BYTES - 1);
  assign status.tail_last = cnt[1:0] == 2'd3;
  assign status.last      = last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_KEY_0_7:   key[0] <= cfg_data;
        REG_KEY_8_15:  key[1] <= cfg_data;
        REG_KEY_16_23: key[2] <= cfg_data;
        REG_KEY_24_31: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash  <= '0;
      ohash <= '0;
      cnt   <= '0;
    end else begin
      if (cmd.finish) begin
        hash  <= '0;
        ohash <= '0;
        cnt   <= '0;
      end else begin
        if (cmd.load) ohash <= '0;
        if (cmd.pad_in_step) hash <= hash_step(hash, pad_byte);
        if (cmd.msg_step && present_r) hash <= hash_step(hash, byte_r);
        if (cmd.pad_out_step) ohash <= hash_step(ohash, pad_byte);
        if (cmd.tail_step) ohash <= tail_res;
        if (cmd.pad_in_step || cmd.pad_out_step || cmd.tail_step) begin
          cnt <= status.pad_last ? '0 : cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r     <= msg_byte;
      present_r  <= byte_present;
      last_r     <= end_of_message;
      expected_r <= expected_tag;
    end
    if (cmd.finish) begin
      tag         <= tail_res;
      tag_matches <= tail_res == expected_r;
    end
  end

endmodule

@@ src/keyed_nested_djb2_xor_tag.sv @@
// Keyed nested djb2-xor tag: top level joining controller and datapath.
// An item in an open message loads and folds its byte; an opening item first folds
// the inner pad. A final item then folds the outer pad and four tail bytes, the last held
// while an earlier result beat waits; result appears the cycle after the last tail step.
// One pad or tail byte is folded per cycle but for that hold; a new item waits for idle.
// Synchronous reset clears key, hash, counter and handshake state.
module keyed_nested_djb2_xor_tag #(
  parameter int PAD_BLOCK_BYTES  = kndxt_pkg::PAD_BLOCK_BYTES_DEF,
  parameter int KEY_LENGTH_BYTES = kndxt_pkg::KEY_LENGTH_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kndxt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kndxt_pkg::KEY_WORD_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kndxt_pkg::BYTE_W-1:0]      msg_byte,
  input  logic                              byte_present,
  input  logic                              end_of_message,
  input  logic [kndxt_pkg::HASH_W-1:0]      expected_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kndxt_pkg::HASH_W-1:0]      tag,
  output logic                              tag_matches
);
  import kndxt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  kndxt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  kndxt_dp #(
    .PAD_BLOCK_BYTES  (PAD_BLOCK_BYTES),
    .KEY_LENGTH_BYTES (KEY_LENGTH_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .msg_byte       (msg_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .expected_tag   (expected_tag),
    .cmd            (cmd),
    .status         (status),
    .tag            (tag),
    .tag_matches    (tag_matches)
  );

endmodule

@@ src/kndxt_checker.sv @@
// Port-level checker for the keyed nested djb2-xor tag block.
// Bound to the top level; depends on kndxt_pkg.
module kndxt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [kndxt_pkg::HASH_W-1:0] tag,
  input logic                         tag_matches
);
  import kndxt_pkg::*;

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is at work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised in the cycle after an input beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tag) && $stable(tag_matches))
    else $error("stalled result beat changed");

endmodule

bind keyed_nested_djb2_xor_tag kndxt_checker u_kndxt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .tag         (tag),
  .tag_matches (tag_matches)
);

@@ verif/keyed_nested_djb2_xor_tag_checker.sv @@
`timescale 1ns / 100ps
// Tag checker for keyed_nested_djb2_xor_tag: follows key writes and message beats,
// predicts each tag and match flag and compares them with result beats in order.
// Depends on kndxt_pkg.
module keyed_nested_djb2_xor_tag_checker #(
  parameter int PAD_BYTES = kndxt_pkg::PAD_BLOCK_BYTES_DEF,
  parameter int KEY_BYTES = kndxt_pkg::KEY_LENGTH_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [kndxt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kndxt_pkg::KEY_WORD_W-1:0]  cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [kndxt_pkg::BYTE_W-1:0]      msg_byte,
  input  logic                              byte_present,
  input  logic                              end_of_message,
  input  logic [kndxt_pkg::HASH_W-1:0]      expected_tag,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [kndxt_pkg::HASH_W-1:0]      tag,
  input  logic                              tag_matches,
  output int                                fail_count,
  output int                                tags_outstanding
);
  import kndxt_pkg::*;

  typedef struct packed {
    logic [HASH_W-1:0] tag;
    logic              match_flag;
  } tag_result_t;

  logic [KEY_WORD_W-1:0] key_word [KEY_WORDS];
  logic [HASH_W-1:0]     msg_hash;
  logic                  msg_open;
  tag_result_t           pending_tags [$];
  int                    fails;

  function automatic logic [HASH_W-1:0] djb2_fold(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    return (h * 32'd33) ^ {{(HASH_W-BYTE_W){1'b0}}, b};
  endfunction

  function automatic logic [HASH_W-1:0] pad_fold(input logic [BYTE_W-1:0] pad);
    logic [HASH_W-1:0] h;
    logic [BYTE_W-1:0] kb;
    int                i;
    h = '0;
    for (i = 0; i < PAD_BYTES; i++) begin
      if (i < KEY_BYTES && i < KEY_WORDS * 8)
        kb = key_word[i / 8][(i % 8) * 8 +: 8];
      else
        kb = '0;
      h = djb2_fold(h, kb ^ pad);
    end
    return h;
  endfunction

  always @(posedge clk) begin : track
    tag_result_t       want;
    logic [HASH_W-1:0] outer;
    int                k;
    if (rst) begin
      for (k = 0; k < KEY_WORDS; k++)
        key_word[k] = '0;
      msg_hash = '0;
      msg_open = 1'b0;
      pending_tags.delete();
      fails = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_tags.size() == 0) begin
          if (fails < 10)
            $display("%0t: result beat with no tag pending: tag %h match %b",
                     $realtime, tag, tag_matches);
          fails++;
        end else begin
          want = pending_tags.pop_front();
          if (tag !== want.tag || tag_matches !== want.match_flag) begin
            if (fails < 10)
              $display("%0t: tag mismatch: expected tag %h match %b, got tag %h match %b",
                       $realtime, want.tag, want.match_flag, tag, tag_matches);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < KEY_WORDS)
        key_word[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        if (!msg_open) begin
          msg_hash = pad_fold(INNER_PAD);
          msg_open = 1'b1;
        end
        if (byte_present)
          msg_hash = djb2_fold(msg_hash, msg_byte);
        if (end_of_message) begin
          outer = pad_fold(OUTER_PAD);
          for (k = 0; k < 4; k++)
            outer = djb2_fold(outer, msg_hash[k * 8 +: 8]);
          want.tag        = outer;
          want.match_flag = (outer == expected_tag);
          pending_tags.push_back(want);
          msg_hash = '0;
          msg_open = 1'b0;
        end
      end
    end
    fail_count       <= fails;
    tags_outstanding <= pending_tags.size();
  end

endmodule

@@ verif/tb_keyed_nested_djb2_xor_tag.sv @@
`timescale 1ns / 100ps
// Testbench top for keyed_nested_djb2_xor_tag: drives key writes and message beats
// with random idling and back-pressure, then gives the verdict.
// Depends on kndxt_pkg, the block and keyed_nested_djb2_xor_tag_checker.
module tb_keyed_nested_djb2_xor_tag;
  import kndxt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * PAD_BLOCK_BYTES_DEF + 16;
  localparam int PHASE_BEATS  = 362;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              present;
  } msg_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  reg_index_t            cfg_index = REG_KEY_0_7;
  logic [KEY_WORD_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     msg_byte = '0;
  logic                  byte_present = 1'b0;
  logic                  end_of_message = 1'b0;
  logic [HASH_W-1:0]     expected_tag = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [HASH_W-1:0]     tag;
  logic                  tag_matches;

  int                    fail_count;
  int                    tags_outstanding;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    cycles = 0;
  logic [HASH_W-1:0]     seen_tag = '0;
  logic [KEY_WORD_W-1:0] key_set [KEY_WORDS];
  msg_beat_t             msg_beats [$];

  keyed_nested_djb2_xor_tag uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .msg_byte(msg_byte),
    .byte_present(byte_present), .end_of_message(end_of_message),
    .expected_tag(expected_tag),
    .out_valid(out_valid), .out_ready(out_ready), .tag(tag), .tag_matches(tag_matches)
  );

  keyed_nested_djb2_xor_tag_checker tag_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .msg_byte(msg_byte),
    .byte_present(byte_present), .end_of_message(end_of_message),
    .expected_tag(expected_tag),
    .out_valid(out_valid), .out_ready(out_ready), .tag(tag), .tag_matches(tag_matches),
    .fail_count(fail_count), .tags_outstanding(tags_outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (out_valid && out_ready)
      seen_tag <= tag;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // drop valid and wait for every pending tag
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tags_outstanding != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key();
    int i;
    for (i = 0; i < KEY_WORDS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data  <= key_set[i];
      @(posedge clk);
      while (!cfg_ready)
        @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic present,
                           input logic last, input logic [HASH_W-1:0] want_tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    msg_byte       <= b;
    byte_present   <= present;
    end_of_message <= last;
    expected_tag   <= want_tag;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  task automatic send_message(input logic [HASH_W-1:0] want_tag);
    int i;
    for (i = 0; i < msg_beats.size(); i++)
      send_beat(msg_beats[i].b, msg_beats[i].present, i == msg_beats.size() - 1,
                want_tag);
  endtask

  task automatic add_beat(input logic [BYTE_W-1:0] b, input logic present);
    msg_beat_t beat;
    beat.b       = b;
    beat.present = present;
    msg_beats.push_back(beat);
  endtask

  task automatic build_message();
    int len;
    int i;
    msg_beats.delete();
    if ($urandom_range(19) == 0) begin
      add_beat(BYTE_W'($urandom), 1'b0);
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      for (i = 0; i < len; i++)
        add_beat(BYTE_W'($urandom), $urandom_range(9) != 0);
    end
  endtask

  function automatic logic [HASH_W-1:0] random_tag();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_WORD_W-1:0] random_key_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return {$urandom_range(1) ? 32'h5555_5555 : 32'hAAAA_AAAA, 32'hAAAA_AAAA};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int ph;
    int i;
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    stall_pct     = 84;

    // key at reset value
    msg_beats.delete();
    add_beat(8'h00, 1'b0);
    send_message(32'h0000_0000);
    drain();
    send_message(seen_tag);
    msg_beats.delete();
    add_beat(8'h00, 1'b1);
    add_beat(8'hFF, 1'b1);
    add_beat(8'h80, 1'b1);
    send_message(32'hFFFF_FFFF);
    msg_beats.delete();
    add_beat(8'h55, 1'b1);
    add_beat(8'hAA, 1'b0);
    add_beat(8'h0F, 1'b0);
    send_message(32'h0000_0000);
    msg_beats.delete();
    add_beat(8'hC3, 1'b0);
    add_beat(8'h01, 1'b1);
    send_message(32'h8000_0001);

    settle();
    for (i = 0; i < KEY_WORDS; i++)
      key_set[i] = '1;
    load_key();
    msg_beats.delete();
    add_beat(8'hFF, 1'b0);
    send_message(32'h7FFF_FFFE);
    msg_beats.delete();
    add_beat(8'hFF, 1'b1);
    send_message(32'h0000_0000);
    drain();
    send_message(seen_tag);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          stall_pct     = 84;
        end
        1: begin
          send_idle_pct = 84;
          stall_pct     = 35;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      settle();
      for (i = 0; i < KEY_WORDS; i++)
        key_set[i] = (ph == 0) ? {$urandom, $urandom} : random_key_word();
      load_key();
      sent = 0;
      while (sent < PHASE_BEATS) begin
        build_message();
        send_message(random_tag());
        sent += msg_beats.size();
        if ($urandom_range(4) == 0) begin
          drain();
          send_message(seen_tag);
          sent += msg_beats.size();
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
